// ===== rtl/c2s_pkg.sv =====
// Package for the complex-to-scalar converter with phase unwrapping.
// Widths, register codes, fixed-point constants, the arctangent table
// and the control types shared by the sequencer, iteration unit and unwrapper.
package c2s_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RUN_BITS    = 16;
  localparam int OUT_BITS    = 40;

  // stream payload widths, padded to whole bytes
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RUN_BITS;
  localparam int MODE_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_REAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IMAG   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAG    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRAP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNWRAP = 3'd4;

  localparam logic [MODE_W-1:0]   MODE_RESET = MODE_MAG;
  localparam logic [RUN_BITS-1:0] RUN_RESET  = RUN_BITS'(64);

  // CORDIC vectoring: vector scaled by 2^32, angle in Q2.30 radians
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_SHIFT = 32;
  localparam int X_W          = SAMPLE_BITS + CORDIC_SHIFT + 4;
  localparam int Z_W          = 35;
  localparam int ANG_FRAC     = 30;
  localparam int ATAN_W       = $clog2(CORDIC_STEPS);

  localparam longint PI_Q30   = 64'd3373259426;
  localparam longint TURN_Q30 = 64'd6746518852;

  localparam int ROUND_SHIFT = ANG_FRAC - FRAC_BITS;

  localparam logic signed [Z_W-1:0] PI_Z       = Z_W'(PI_Q30);
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(longint'(1) << (ROUND_SHIFT - 1));

  localparam logic signed [OUT_BITS-1:0] PI_OUT =
    OUT_BITS'((PI_Q30 + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);

  // one full turn at the output scale
  localparam int TURN_W = FRAC_BITS + 4;
  localparam logic signed [TURN_W-1:0] TURN =
    TURN_W'((TURN_Q30 + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);

  localparam int TC_W = 16;

  // square root of (re^2 + im^2) * 2^(2*FRAC_BITS), rounded to nearest
  localparam int RAD_W     = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int REM_W     = ROOT_BITS + 2;

  localparam int ITER_MAX = (ROOT_BITS > CORDIC_STEPS) ? ROOT_BITS : CORDIC_STEPS;
  localparam int CNT_W    = $clog2(ITER_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_SCALE,
    ST_UNWRAP,
    ST_OUT
  } c2s_state_t;

  typedef enum logic [2:0] {
    IT_IDLE,
    IT_SQ_RE,
    IT_SQ_IM,
    IT_ROOT,
    IT_ROT,
    IT_FIN
  } c2s_iter_state_t;

  typedef enum logic {
    OP_ROOT,
    OP_ATAN
  } c2s_op_t;

  typedef struct packed {
    logic    start;
    c2s_op_t op;
  } c2s_iter_ctrl_t;

  typedef struct packed {
    logic begin_item;
    logic scale;
    logic update;
  } c2s_unw_ctrl_t;

  // atan(2^-i) in Q2.30, truncated (the last entry rounded up)
  function automatic logic [31:0] atan_q30(input logic [ATAN_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      24:      v = 32'h0000003F;
      25:      v = 32'h0000001F;
      26:      v = 32'h0000000F;
      27:      v = 32'h00000008;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/c2s_iter.sv =====
// Shared iteration unit: CORDIC vectoring for the phase, or a digit-by-digit
// square root for the magnitude, one step per cycle under a small FSM.
// Depends on c2s_pkg.
module c2s_iter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  c2s_pkg::c2s_iter_ctrl_t              ctrl,
  input  logic signed [c2s_pkg::SAMPLE_BITS-1:0] re,
  input  logic signed [c2s_pkg::SAMPLE_BITS-1:0] im,
  output logic                                 done,
  output logic signed [c2s_pkg::OUT_BITS-1:0]  result
);
  import c2s_pkg::*;

  c2s_iter_state_t state, state_next;
  c2s_op_t         op;
  logic [CNT_W-1:0] cnt;

  // CORDIC registers
  logic signed [X_W-1:0] x, y;
  logic signed [Z_W-1:0] z;

  // square root registers
  logic [RAD_W-1:0]     rad;
  logic [RAD_W-1:0]     sq;
  logic [REM_W-1:0]     rem;
  logic [ROOT_BITS-1:0] root;

  // shared multiplier for the two squares
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [RAD_W-1:0]       mul_p;

  // CORDIC step
  logic signed [X_W-1:0] xs, dx, dy;
  logic signed [Z_W-1:0] ang, zc, zr;
  logic                  y_pos, y_neg;

  // square root step
  logic [REM_W+1:0] trial, tsub;
  logic             ge;
  logic [ROOT_BITS:0] root_fin;

  logic last_root, last_rot;

  assign mul_a = (state == IT_SQ_RE) ? re : im;
  assign mul_p = RAD_W'(mul_a * mul_a);

  assign xs    = X_W'(re) <<< CORDIC_SHIFT;
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign ang   = Z_W'(atan_q30(cnt[ATAN_W-1:0]));
  assign y_pos = (y != '0) && !y[X_W-1];
  assign y_neg = y[X_W-1];

  assign trial = {rem, rad[RAD_W-1 -: 2]};
  assign tsub  = (REM_W + 2)'({root, 2'b01});
  assign ge    = trial >= tsub;

  assign last_root = cnt == CNT_W'(ROOT_BITS - 1);
  assign last_rot  = cnt == CNT_W'(CORDIC_STEPS - 1);

  always_comb begin
    state_next = state;
    case (state)
      IT_IDLE: begin
        if (ctrl.start) state_next = (ctrl.op == OP_ROOT) ? IT_SQ_RE : IT_ROT;
      end
      IT_SQ_RE: state_next = IT_SQ_IM;
      IT_SQ_IM: state_next = IT_ROOT;
      IT_ROOT: begin
        if (last_root) state_next = IT_FIN;
      end
      IT_ROT: begin
        if (last_rot) state_next = IT_FIN;
      end
      IT_FIN:  state_next = IT_IDLE;
      default: state_next = IT_IDLE;
    endcase
  end

  // clamp to [-pi, pi], round half up, or round the root to nearest
  always_comb begin
    zc = z;
    if (z > PI_Z) zc = PI_Z;
    if (z < -PI_Z) zc = -PI_Z;
    zr = (zc + ROUND_HALF) >>> ROUND_SHIFT;
    root_fin = ((REM_W)'(root) < rem) ? ((ROOT_BITS + 1)'(root) + 1'b1)
                                      : (ROOT_BITS + 1)'(root);
    done   = state == IT_FIN;
    result = (op == OP_ATAN) ? OUT_BITS'(zr) : OUT_BITS'($signed({1'b0, root_fin}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      IT_IDLE: begin
        cnt <= '0;
        if (ctrl.start) begin
          op <= ctrl.op;
          x  <= re[SAMPLE_BITS-1] ? -xs : xs;
          y  <= re[SAMPLE_BITS-1] ? -(X_W'(im) <<< CORDIC_SHIFT) : (X_W'(im) <<< CORDIC_SHIFT);
          if (!re[SAMPLE_BITS-1]) z <= '0;
          else z <= im[SAMPLE_BITS-1] ? -PI_Z : PI_Z;
        end
      end
      IT_SQ_RE: sq <= mul_p;
      IT_SQ_IM: begin
        rad  <= sq + mul_p;
        rem  <= '0;
        root <= '0;
      end
      IT_ROOT: begin
        rem  <= ge ? REM_W'(trial - tsub) : REM_W'(trial);
        root <= {root[ROOT_BITS-2:0], ge};
        rad  <= {rad[RAD_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
      end
      IT_ROT: begin
        // a step with y at zero leaves the vector alone
        if (y_pos) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end else if (y_neg) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/c2s_unwrap.sv =====
// Unwrap state: run position, last unwrapped phase and saturating turn count.
// Adds the turn offset, then steps one turn towards the last phase.
// Depends on c2s_pkg.
module c2s_unwrap (
  input  logic                                 clk,
  input  logic                                 rst,
  input  c2s_pkg::c2s_unw_ctrl_t               ctrl,
  input  logic [c2s_pkg::RUN_BITS-1:0]         run_len,
  input  logic signed [c2s_pkg::OUT_BITS-1:0]  wrapped,
  output logic signed [c2s_pkg::OUT_BITS-1:0]  phase
);
  import c2s_pkg::*;

  localparam int PROD_W = TC_W + TURN_W;
  localparam int D_W    = OUT_BITS + 1;
  localparam int E_W    = D_W + 2;
  localparam logic signed [TC_W-1:0] TC_MAX = {1'b0, {(TC_W - 1){1'b1}}};
  localparam logic signed [TC_W-1:0] TC_MIN = {1'b1, {(TC_W - 1){1'b0}}};

  logic [RUN_BITS-1:0]        run_position;
  logic signed [OUT_BITS-1:0] previous_phase;
  logic signed [TC_W-1:0]     turn_count;
  logic signed [OUT_BITS-1:0] ph;

  logic signed [PROD_W-1:0] offset;
  logic signed [D_W-1:0]    d;
  logic signed [E_W-1:0]    up_val, dn_val;
  logic                     up, dn;

  assign offset = PROD_W'(turn_count) * PROD_W'(TURN);
  assign d      = D_W'(ph) - D_W'(previous_phase);
  // |d + T| < |d| is 2d + T < 0; |d - T| < |d| is 2d - T > 0
  assign up_val = (E_W'(d) <<< 1) + E_W'(TURN);
  assign dn_val = (E_W'(d) <<< 1) - E_W'(TURN);
  assign up     = up_val[E_W-1];
  assign dn     = !dn_val[E_W-1] && (dn_val != '0);
  assign phase  = previous_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_position   <= '0;
      previous_phase <= '0;
      turn_count     <= '0;
    end else begin
      if (ctrl.begin_item) begin
        if (run_position >= run_len) begin
          run_position   <= RUN_BITS'(1);
          previous_phase <= '0;
          turn_count     <= '0;
        end else begin
          run_position <= run_position + 1'b1;
        end
      end
      if (ctrl.update) begin
        if (up) begin
          if (turn_count != TC_MAX) begin
            turn_count     <= turn_count + 1'b1;
            previous_phase <= ph + OUT_BITS'(TURN);
          end else begin
            previous_phase <= ph;
          end
        end else if (dn && (turn_count != TC_MIN)) begin
          turn_count     <= turn_count - 1'b1;
          previous_phase <= ph - OUT_BITS'(TURN);
        end else begin
          previous_phase <= ph;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scale) ph <= wrapped + OUT_BITS'(offset);
  end

endmodule

// ===== rtl/complex_to_scalar_with_phase_unwrap.sv =====
// Complex sample to scalar (real, imaginary, magnitude, wrapped or unwrapped
// phase) in signed fixed point. One item in flight at a time.
// Real, imaginary and undefined modes pass from preparation to output; wrapped
// phase runs 28 CORDIC steps, unwrapped also scales and unwraps, magnitude
// squares, then finds 32 root digits. A new item waits until the last is loaded.
// Synchronous reset: mode magnitude, run length 64, unwrap state cleared.
module complex_to_scalar_with_phase_unwrap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [c2s_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c2s_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [c2s_pkg::IN_W-1:0]          s_tdata,  // real_part, imag_part
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [c2s_pkg::OUT_W-1:0]         m_tdata   // scalar_value
);
  import c2s_pkg::*;

  c2s_state_t state, state_next;

  logic [MODE_W-1:0]   mode;
  logic [RUN_BITS-1:0] run_len;

  logic signed [SAMPLE_BITS-1:0] re_q, im_q;
  logic signed [OUT_BITS-1:0]    result;
  logic signed [OUT_BITS-1:0]    direct;

  c2s_iter_ctrl_t iter_ctrl;
  c2s_unw_ctrl_t  unw_ctrl;
  logic           iter_done;
  logic signed [OUT_BITS-1:0] iter_result;
  logic signed [OUT_BITS-1:0] unw_phase;

  logic needs_calc, out_load;

  assign cfg_ready  = 1'b1;
  assign needs_calc = (mode == MODE_MAG) || (mode == MODE_WRAP) || (mode == MODE_UNWRAP);

  always_comb begin
    case (mode)
      MODE_REAL: direct = OUT_BITS'(re_q) <<< FRAC_BITS;
      MODE_IMAG: direct = OUT_BITS'(im_q) <<< FRAC_BITS;
      default:   direct = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PREP;
      end
      ST_PREP: state_next = needs_calc ? ST_CALC : ST_OUT;
      ST_CALC: begin
        if (iter_done) state_next = (mode == MODE_UNWRAP) ? ST_SCALE : ST_OUT;
      end
      ST_SCALE:  state_next = ST_UNWRAP;
      ST_UNWRAP: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready            = state == ST_IDLE;
    iter_ctrl.start     = (state == ST_PREP) && needs_calc;
    iter_ctrl.op        = (mode == MODE_MAG) ? OP_ROOT : OP_ATAN;
    unw_ctrl.begin_item = state == ST_PREP;
    unw_ctrl.scale      = state == ST_SCALE;
    unw_ctrl.update     = state == ST_UNWRAP;
    out_load            = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_RESET;
      run_len  <= RUN_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:       mode    <= cfg_data[MODE_W-1:0];
          REG_RUN_LENGTH: run_len <= cfg_data[RUN_BITS-1:0];
          default: ;
        endcase
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      re_q <= s_tdata[SAMPLE_BITS-1:0];
      im_q <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (state == ST_PREP) result <= direct;
    if (iter_done) result <= iter_result;
    if (out_load) begin
      m_tdata <= (mode == MODE_UNWRAP) ? OUT_W'($unsigned(unw_phase))
                                       : OUT_W'($unsigned(result));
    end
  end

  c2s_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (iter_ctrl),
    .re     (re_q),
    .im     (im_q),
    .done   (iter_done),
    .result (iter_result)
  );

  c2s_unwrap u_unwrap (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (unw_ctrl),
    .run_len (run_len),
    .wrapped (result),
    .phase   (unw_phase)
  );

  // iteration unit only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) iter_done |-> state == ST_CALC)
    else $error("iteration unit finished outside the calculation state");

  // an accepted item always goes to preparation next
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_PREP)
    else $error("accepted item not taken into preparation");

  // unwrap scale and update steps happen only in unwrapped-phase mode
  assert property (@(posedge clk) disable iff (rst)
    (unw_ctrl.update || unw_ctrl.scale) |-> mode == MODE_UNWRAP)
    else $error("unwrap step outside unwrapped-phase mode");

  // magnitude is never negative
  assert property (@(posedge clk) disable iff (rst)
    (iter_done && mode == MODE_MAG) |-> !iter_result[OUT_BITS-1])
    else $error("negative magnitude");

  // wrapped phase stays within plus and minus pi
  assert property (@(posedge clk) disable iff (rst)
    (iter_done && mode != MODE_MAG) |-> (iter_result <= PI_OUT && iter_result >= -PI_OUT))
    else $error("wrapped phase out of range");

endmodule
